// ----- rtl/core/ssrch_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ssrch_pkg
// Shared types, widths and helpers for the stream substring search block.
// -----------------------------------------------------------------------------
package ssrch_pkg;

   localparam int DATA_W    = 8;
   localparam int OFFSET_W  = 32;
   localparam int PATTERN_W = 64;
   localparam int LENGTH_W  = 4;
   localparam int LEN_IDX_W = 3;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 1'b1;

   typedef struct packed {
      logic [DATA_W-1:0]   data_byte;
      logic                first_byte;
      logic                last_byte;
      logic [OFFSET_W-1:0] base_offset;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [OFFSET_W-1:0] match_offset;
   } rsp_type;

   // stream control that rides along with each classified byte
   typedef struct packed {
      logic                first_byte;
      logic                last_byte;
      logic [OFFSET_W-1:0] base_offset;
   } cls_type;

   // clamp the programmed length into 1..max_len and return length-1
   function automatic logic [LEN_IDX_W-1:0] eff_len_m1(input logic [LENGTH_W-1:0] len,
                                                      input int max_len);
      logic [LENGTH_W-1:0] n;
      n = len;
      if (n == '0) begin
         n = LENGTH_W'(1);
      end
      if (int'(n) > max_len) begin
         n = LENGTH_W'(max_len);
      end
      return LEN_IDX_W'(n - LENGTH_W'(1));
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ssrch_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ssrch_fifo
// Small register queue with push/full and pop/empty on the two sides.
// -----------------------------------------------------------------------------
module ssrch_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/ssrch_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ssrch_front
// Classifies an incoming byte: compares it against every pattern byte at once.
// -----------------------------------------------------------------------------
module ssrch_front #(
   parameter int MAX_PATTERN = 8
) (
   input  wire logic [ssrch_pkg::PATTERN_W-1:0] pattern,
   input  wire ssrch_pkg::req_type              req_data,
   output logic      [MAX_PATTERN-1:0]          hits,
   output ssrch_pkg::cls_type                   cls
);

   import ssrch_pkg::*;

   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         hits[i] = (pattern[DATA_W*i +: DATA_W] == req_data.data_byte);
      end
   end

   always_comb begin
      cls.first_byte  = req_data.first_byte;
      cls.last_byte   = req_data.last_byte;
      cls.base_offset = req_data.base_offset;
   end

endmodule
`default_nettype wire

// ----- rtl/core/ssrch_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ssrch_back
// Shift-and match engine: tracks live prefixes and the byte offset, and
// emits one result per stream.
// -----------------------------------------------------------------------------
module ssrch_back #(
   parameter int MAX_PATTERN = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [ssrch_pkg::LEN_IDX_W-1:0] len_m1,
   input  wire logic                            mid_empty,
   input  wire logic [MAX_PATTERN-1:0]          mid_hits,
   input  wire ssrch_pkg::cls_type              mid_cls,
   output logic                                 mid_pop,
   input  wire logic                            rsp_full,
   output logic                                 rsp_push,
   output ssrch_pkg::rsp_type                   rsp_wdata
);

   import ssrch_pkg::*;

   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [MAX_PATTERN-1:0] live_ff, live_in;
   logic [OFFSET_W-1:0]    pos_ff, pos_in;
   logic                   done_ff, done_in;

   logic [MAX_PATTERN-1:0] len_mask;
   logic [MAX_PATTERN-1:0] live_base, live_next;
   logic [OFFSET_W-1:0]    pos_base;
   logic                   done_base;
   logic                   hit_end;

   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         len_mask[i] = (LEN_IDX_W'(i) <= len_m1);
      end
   end

   // hold the beat while the result queue has no room
   assign mid_pop = ~mid_empty & ~rsp_full;

   always_comb begin
      live_base = mid_cls.first_byte ? '0 : live_ff;
      pos_base  = mid_cls.first_byte ? mid_cls.base_offset : pos_ff;
      done_base = mid_cls.first_byte ? 1'b0 : done_ff;
      live_next = ((live_base << 1) | MAX_PATTERN'(1)) & mid_hits & len_mask;
      hit_end   = live_next[len_m1[IDX_W-1:0]];
   end

   always_comb begin
      live_in  = live_ff;
      pos_in   = pos_ff;
      done_in  = done_ff;
      rsp_push = 1'b0;
      rsp_wdata.found        = hit_end;
      rsp_wdata.match_offset = hit_end ? pos_base - OFFSET_W'(len_m1) : '0;
      if (mid_pop) begin
         live_in = live_base;
         pos_in  = pos_base;
         done_in = done_base;
         // drop bytes once this stream has its result
         if (!done_base) begin
            live_in  = live_next;
            pos_in   = pos_base + OFFSET_W'(1);
            rsp_push = hit_end | mid_cls.last_byte;
            done_in  = hit_end | mid_cls.last_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
         pos_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
         pos_ff  <= pos_in;
         done_ff <= done_in;
      end
   end

   a_push_from_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> mid_pop)
      else $error("result pushed without consuming a byte");

   a_done_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> done_ff)
      else $error("search not closed after a result");

   a_quiet_when_done: assert property (@(posedge clock) disable iff (reset)
      (mid_pop && done_ff && !mid_cls.first_byte) |-> !rsp_push)
      else $error("result given for a closed stream");

   a_miss_offset_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && !rsp_wdata.found) |-> (rsp_wdata.match_offset == '0))
      else $error("nonzero offset on a miss");

endmodule
`default_nettype wire

// ----- rtl/core/stream_substring_search.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// stream_substring_search
// First-occurrence exact search of a programmed byte pattern in a byte stream.
// -----------------------------------------------------------------------------
// Takes one byte per cycle while req_full is low. Each accepted byte is compared
// against all pattern bytes at once and queued; the shift-and engine behind the
// queue retires one byte per cycle while the result queue has room, so the
// sustained rate is one byte per clock, set by the prefix update. A result is
// registered into the result queue when the engine retires the byte that
// completes the pattern (or ends the stream), and can then be popped. Each
// stream, started by a byte with first_byte set, yields exactly one result:
// found with the offset of the first matched byte, or found=0 at last_byte.
// Bytes after a result are dropped until the next first_byte. Write the
// pattern registers only while no bytes are in flight.
module stream_substring_search #(
   parameter int MAX_PATTERN = 8,
   parameter int MID_DEPTH   = 4,
   parameter int RSP_DEPTH   = 2
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   input  wire ssrch_pkg::req_type              req_data,
   output logic                                 req_full,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output ssrch_pkg::rsp_type                   rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [ssrch_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ssrch_pkg::PATTERN_W-1:0] csr_wdata
);

   import ssrch_pkg::*;

   localparam int MID_W = MAX_PATTERN + $bits(cls_type);

   logic [PATTERN_W-1:0]   pattern_ff;
   logic [LENGTH_W-1:0]    length_ff;
   logic [LEN_IDX_W-1:0]   len_m1;

   logic [MAX_PATTERN-1:0] front_hits, mid_hits;
   cls_type                front_cls, mid_cls;
   logic [MID_W-1:0]       mid_rdata;
   logic                   mid_empty, mid_pop;
   logic                   rsp_full, rsp_push;
   rsp_type                rsp_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= LENGTH_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_BYTES: begin
               pattern_ff <= csr_wdata;
            end
            CSR_PATTERN_LENGTH: begin
               length_ff <= csr_wdata[LENGTH_W-1:0];
            end
            default: begin
               pattern_ff <= pattern_ff;
            end
         endcase
      end
   end

   assign len_m1 = eff_len_m1(length_ff, MAX_PATTERN);

   ssrch_front #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_front (
      .pattern  (pattern_ff),
      .req_data (req_data),
      .hits     (front_hits),
      .cls      (front_cls)
   );

   ssrch_fifo #(
      .WIDTH(MID_W),
      .DEPTH(MID_DEPTH)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata ({front_hits, front_cls}),
      .full  (req_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   assign mid_hits = mid_rdata[MID_W-1 -: MAX_PATTERN];
   assign mid_cls  = cls_type'(mid_rdata[$bits(cls_type)-1:0]);

   ssrch_back #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .len_m1    (len_m1),
      .mid_empty (mid_empty),
      .mid_hits  (mid_hits),
      .mid_cls   (mid_cls),
      .mid_pop   (mid_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_wdata (rsp_wdata)
   );

   ssrch_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wdata),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

endmodule
`default_nettype wire
